// ===== hdl/mmu_pkg.sv =====
// shared types, codes and helpers for the matrix multiply unit
`default_nettype none

package mmu_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } dims_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [OUT_W-1:0] value;
        logic             last;
    } res_t;

    // zero reads as one, anything above the cap reads as the cap
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int cap);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > cap)
        begin
            r = DIM_W'(cap);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mmu_fifo.sv =====
// small first-in first-out queue used between the stages
`default_nettype none

module mmu_fifo
    import mmu_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   empty,
    output logic                   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mmu_front.sv =====
// front end: takes requests, classifies them and queues commands
`default_nettype none

module mmu_front
    import mmu_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          mode,
    input  wire logic [IDX_W-1:0]    row,
    input  wire logic [IDX_W-1:0]    col,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic                cmd_pop,
    output logic                     cmd_empty,
    output cmd_t                     cmd
);

    localparam int KEPT = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;

    cmd_t             cmd_in;
    logic             keep;
    logic             q_wr;
    logic [$bits(cmd_t)-1:0] q_rd_data;

    // loads outside the store and the unused mode are dropped here
    always_comb
    begin
        cmd_in.row   = row;
        cmd_in.col   = col;
        cmd_in.value = VALUE_W'($signed(value[KEPT-1:0]));
        cmd_in.kind  = CMD_COMPUTE;
        keep         = 1'b0;
        unique case (mode) inside
            MODE_LOAD_A, MODE_LOAD_B:
            begin
                cmd_in.kind = (mode == MODE_LOAD_A) ? CMD_LOAD_A : CMD_LOAD_B;
                keep        = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
            end
            MODE_COMPUTE:
            begin
                cmd_in.kind = CMD_COMPUTE;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_wr = push && !full && keep;
    assign cmd  = cmd_t'(q_rd_data);

    mmu_fifo #(
        .DATA_W ($bits(cmd_t)),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (q_rd_data),
        .empty   (cmd_empty),
        .full    (full)
    );

endmodule

`default_nettype wire

// ===== hdl/mmu_back.sv =====
// back end: element stores, multiply-accumulate sequencer and result queue
`default_nettype none

module mmu_back
    import mmu_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_empty,
    input  wire cmd_t  cmd,
    output logic       cmd_pop,
    input  wire dims_t dims,
    input  wire logic  pop,
    output logic       empty,
    output res_t       res
);

    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int DEPTH   = DIM_CAP * DIM_CAP;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KEPT    = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam int PROD_W  = 2 * KEPT;
    localparam int ACC_W   = PROD_W + 4;
    localparam int SAT_W   = (ACC_W > 33) ? ACC_W : 33;
    localparam int CRED_W  = $clog2(RES_DEPTH + 1);
    localparam int AW2     = 2 * IDX_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    typedef struct packed {
        logic             first;
        logic             last;
        logic             fin;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    logic [KEPT-1:0] mem_a [DEPTH];
    logic [KEPT-1:0] mem_b [DEPTH];

    logic                    state_reg, state_next;
    logic [IDX_W-1:0]        r_reg, r_next;
    logic [IDX_W-1:0]        c_reg, c_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [CRED_W-1:0]       credit_reg, credit_next;

    logic                    we_a, we_b;
    logic [ADDR_W-1:0]       wr_addr, rd_addr_a, rd_addr_b;
    logic signed [KEPT-1:0]  rd_a_reg, rd_b_reg;

    logic                    issue, elem_start, last_i, last_r, last_c;
    logic                    s1_valid_reg, s2_valid_reg, done_reg;
    tag_t                    s1_tag_reg, s2_tag_reg, s3_tag_reg, tag_now;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SAT_W-1:0]  acc_ext;
    logic [SAT_W-32:0]       acc_hi;
    logic [OUT_W-1:0]        sat_value;
    res_t                    res_in;
    logic                    res_full;
    logic [$bits(res_t)-1:0] res_rd_data;

    assign last_i     = ({1'b0, i_reg} == DIM_W'(dims.nk - 1'b1));
    assign last_r     = ({1'b0, r_reg} == DIM_W'(dims.nr - 1'b1));
    assign last_c     = ({1'b0, c_reg} == DIM_W'(dims.nc - 1'b1));
    assign elem_start = (i_reg == '0);
    assign issue      = (state_reg == S_RUN) && (!elem_start || credit_reg != '0);

    assign wr_addr   = ADDR_W'({{IDX_W{1'b0}}, cmd.row} * AW2'(DIM_CAP) + {{IDX_W{1'b0}}, cmd.col});
    assign rd_addr_a = ADDR_W'({{IDX_W{1'b0}}, r_reg} * AW2'(DIM_CAP) + {{IDX_W{1'b0}}, i_reg});
    assign rd_addr_b = ADDR_W'({{IDX_W{1'b0}}, i_reg} * AW2'(DIM_CAP) + {{IDX_W{1'b0}}, c_reg});

    assign tag_now.first = elem_start;
    assign tag_now.last  = last_i;
    assign tag_now.fin   = last_i && last_r && last_c;
    assign tag_now.row   = r_reg;
    assign tag_now.col   = c_reg;

    // sequencer: loads are carried out while idle, a compute walks c, r, i
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        cmd_pop    = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    we_a    = (cmd.kind == CMD_LOAD_A);
                    we_b    = (cmd.kind == CMD_LOAD_B);
                    if (cmd.kind == CMD_COMPUTE)
                    begin
                        state_next = S_RUN;
                        r_next     = '0;
                        c_next     = '0;
                        i_next     = '0;
                    end
                end
            end
            S_RUN:
            begin
                if (issue)
                begin
                    if (!last_i)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        i_next = '0;
                        if (!last_r)
                        begin
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            r_next = '0;
                            c_next = c_reg + 1'b1;
                            if (last_c)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a result slot is reserved when an element starts and freed on pop
    always_comb
    begin
        credit_next = credit_reg;
        if (issue && elem_start)
        begin
            credit_next = credit_next - 1'b1;
        end
        if (pop && !empty)
        begin
            credit_next = credit_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            i_reg        <= '0;
            credit_reg   <= CRED_W'(RES_DEPTH);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            i_reg        <= i_next;
            credit_reg   <= credit_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && s2_tag_reg.last;
        end
    end

    // element stores with registered read
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= cmd.value[KEPT-1:0];
        end
        if (we_b)
        begin
            mem_b[wr_addr] <= cmd.value[KEPT-1:0];
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    assign acc_next = s2_tag_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // multiply stage, then accumulate stage
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= tag_now;
        prod_reg   <= PROD_W'(rd_a_reg) * PROD_W'(rd_b_reg);
        s2_tag_reg <= s1_tag_reg;
        if (s2_valid_reg)
        begin
            acc_reg    <= acc_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // saturate to 32 bits when the upper bits are not a sign extension
    assign acc_ext = SAT_W'(acc_reg);
    assign acc_hi  = acc_ext[SAT_W-1:31];
    always_comb
    begin
        if ((&acc_hi) || !(|acc_hi))
        begin
            sat_value = acc_ext[31:0];
        end
        else
        begin
            sat_value = acc_ext[SAT_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign res_in.row   = s3_tag_reg.row;
    assign res_in.col   = s3_tag_reg.col;
    assign res_in.value = sat_value;
    assign res_in.last  = s3_tag_reg.fin;
    assign res          = res_t'(res_rd_data);

    mmu_fifo #(
        .DATA_W ($bits(res_t)),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (done_reg),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty),
        .full    (res_full)
    );

    // slots are reserved ahead, so the queue is never written while full
    logic unused_full;
    assign unused_full = res_full;

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_unit.sv =====
// top level of the matrix multiply unit
`default_nettype none

// matrix multiply unit, C = A x B on signed Q8.8 elements.
// requests enter through a queue interface (push / full) and carry a mode:
// load A element, load B element, or compute. loads write one element of the
// A or B store at (row, col); a compute request emits every element of C in
// column-major order (column 0 rows 0..rows_a-1 first), each as signed
// Q16.16 saturated to 32 bits, with last_result marking the final element.
// results leave through a second queue (empty / pop).
// sizes come from three configuration registers (rows_a, inner_dim, cols_b),
// written through cfg_we / cfg_index / cfg_wdata; the user must write them only
// while idle (not enforced); zero counts as one, sizes above the store dimension are capped.
// rate: one shared multiply-accumulate unit reads one A and one B element per
// cycle from the two element stores, but it stalls at the start of an element
// while every result slot is reserved; a slot is freed when its result is popped.
// a request is accepted whenever the command queue has room, so the next
// request can be queued while a compute is still running.
// the element stores have no reset and no clearing pass: entries must be
// loaded before a compute reads them.

module matrix_multiply_unit
    import mmu_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request side
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            mode,
    input  wire logic [IDX_W-1:0]      row,
    input  wire logic [IDX_W-1:0]      col,
    input  wire logic signed [VALUE_W-1:0] value,
    // result side
    output logic                       empty,
    input  wire logic                  pop,
    output logic [IDX_W-1:0]           out_row,
    output logic [IDX_W-1:0]           out_col,
    output logic signed [OUT_W-1:0]   out_value,
    output logic                       last_result,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_wdata
);

    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_dim_reg;
    logic [DIM_W-1:0] cols_b_reg;
    dims_t            dims;

    cmd_t             cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    res_t             res;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_W'(8);
            inner_dim_reg <= DIM_W'(8);
            cols_b_reg    <= DIM_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                CFG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // effective sizes after clamping
    assign dims.nr = clamp_dim(rows_a_reg, DIM_CAP);
    assign dims.nk = clamp_dim(inner_dim_reg, DIM_CAP);
    assign dims.nc = clamp_dim(cols_b_reg, DIM_CAP);

    mmu_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    mmu_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .dims      (dims),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // unpack the oldest waiting result
    assign out_row     = res.row;
    assign out_col     = res.col;
    assign out_value   = res.value;
    assign last_result = res.last;

endmodule

`default_nettype wire

// ===== hdl/mmu_checker.sv =====
// port-level checks for the matrix multiply unit, bound to the top level
`default_nettype none

module mmu_checker
    import mmu_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 push,
    input wire logic                 full,
    input wire logic                 empty,
    input wire logic                 pop,
    input wire logic [IDX_W-1:0]     out_row,
    input wire logic [IDX_W-1:0]     out_col,
    input wire logic [OUT_W-1:0]     out_value,
    input wire logic                 last_result
);

    // no result is waiting in the cycle after reset is sampled low
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // the request queue only fills up because of an accepted request
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    // a waiting result stays until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result withdrawn");

    // and its payload does not change meanwhile
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_row) && $stable(out_col)
                              && $stable(out_value) && $stable(last_result)))
        else $error("waiting result changed");

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (.*);

`default_nettype wire
